### rtl/sensor_calibrate_filter_range_core_defines.svh
// Assertion macros shared by the sensor calibration core.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef SENSOR_CALIBRATE_FILTER_RANGE_CORE_DEFINES_SVH
`define SENSOR_CALIBRATE_FILTER_RANGE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SCFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SCFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scfr_pkg.sv
// Shared types and constants of the sensor calibration core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package scfr_pkg;

  // Default parameter values
  localparam int DEF_FRACTION_BITS   = 16;
  localparam int DEF_MAX_POLY_DEGREE = 5;
  localparam int DEF_QUEUE_DEPTH     = 4;

  // Configuration port geometry
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // Register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_LINEAR = 3'd1;
  localparam logic [2:0] REG_TP_RAW = 3'd2;
  localparam logic [2:0] REG_TP_REF = 3'd3;
  localparam logic [2:0] REG_C01    = 3'd4;
  localparam logic [2:0] REG_C23    = 3'd5;
  localparam logic [2:0] REG_C45    = 3'd6;
  localparam logic [2:0] REG_RANGE  = 3'd7;

  // Calibration mode codes
  localparam logic [2:0] MODE_LINEAR    = 3'd1;
  localparam logic [2:0] MODE_TWO_POINT = 3'd2;
  localparam logic [2:0] MODE_POLY      = 3'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  // Intermediate magnitude limit, 2^40 LSB
  localparam logic [40:0] WIDE_LIMIT = {1'b1, 40'd0};

  // Work decided at the front for each sample
  typedef enum logic [2:0] {
    OP_ERR,
    OP_PASS,
    OP_LIN,
    OP_TWO,
    OP_POLY
  } op_t;

  typedef struct packed {
    logic signed [31:0] sample;
    op_t                op;
  } item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [21:0] mode;
    logic [63:0] lin;
    logic [63:0] tp_raw;
    logic [63:0] tp_ref;
    logic [63:0] c01;
    logic [63:0] c23;
    logic [63:0] c45;
    logic [63:0] lim;
  } cfg_t;

endpackage

### rtl/scfr_mul.sv
// Serial fixed-point multiplier: one 21x21 partial product per cycle.
// Forms a rounded, clamped (a*b) >> FRACTION_BITS; uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_mul
  import scfr_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [41:0] a_in,
  input  logic signed [41:0] b_in,
  output logic               done,
  output logic signed [41:0] result
);

  localparam logic [65:0] RND = 66'(1) << (FRACTION_BITS - 1);

  logic        busy_r, done_r, neg_r, sat_r;
  logic [2:0]  step_r;
  logic [40:0] a_r, b_r;
  logic [41:0] prod_r;
  logic [63:0] ph_r;
  logic [64:0] p_r;
  logic signed [41:0] res_r;

  logic [20:0] ma, mb;
  logic [41:0] mprod;
  logic [65:0] rsum, rshift;
  logic [40:0] mag;

  // Clamp a signed operand to a magnitude of 2^40
  function automatic logic [40:0] clamp_mag(input logic signed [41:0] v);
    logic [41:0] m;
    m = v[41] ? 42'(-v) : 42'(v);
    if (m > 42'(WIDE_LIMIT)) begin
      return WIDE_LIMIT;
    end
    return m[40:0];
  endfunction

  // Select halves: step 0 lo*hi, 1 hi*hi, 2 lo*lo, 3 hi*lo
  assign ma = (step_r == 3'd1 || step_r == 3'd3) ? {1'b0, a_r[40:21]} : a_r[20:0];
  assign mb = (step_r <= 3'd1) ? b_r[40:20] : {1'b0, b_r[19:0]};
  assign mprod = ma * mb;

  // Round and clamp the finished product
  assign rsum   = {1'b0, p_r} + RND;
  assign rshift = rsum >> FRACTION_BITS;
  assign mag    = (sat_r || rshift > 66'(WIDE_LIMIT)) ? WIDE_LIMIT : rshift[40:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    // Datapath
    if (start) begin
      a_r   <= clamp_mag(a_in);
      b_r   <= clamp_mag(b_in);
      neg_r <= a_in[41] != b_in[41];
    end else if (busy_r) begin
      prod_r <= mprod;
      case (step_r)
        3'd1: ph_r <= 64'(prod_r);
        3'd2: ph_r <= ph_r + (64'(prod_r) << 21);
        3'd3: begin
          sat_r <= ph_r[63:43] != 21'd0;
          p_r   <= (65'(ph_r[42:0]) << 20) + 65'(prod_r);
        end
        3'd4: p_r <= p_r + (65'(prod_r) << 21);
        3'd5: res_r <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        default: ;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### rtl/scfr_div.sv
// Restoring divider for the two-point slope, one quotient bit per cycle.
// Gives (num << FRACTION_BITS) / den toward zero, clamped to 2^40; uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_div
  import scfr_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [41:0] quot
);

  localparam int NW = 33 + FRACTION_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [32:0]   rem_r, dmag_r;
  logic [NW-1:0] q_r;
  logic [33:0]   trial;
  logic          fits;
  logic [40:0]   qmag;

  assign trial = {rem_r, q_r[NW-1]};
  assign fits  = trial >= {1'b0, dmag_r};

  // Clamp and sign the quotient
  assign qmag = (q_r > NW'(WIDE_LIMIT)) ? WIDE_LIMIT : q_r[40:0];
  assign quot = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    // Datapath: shift one dividend bit into the remainder
    if (start) begin
      rem_r  <= '0;
      dmag_r <= den[32] ? 33'(-den) : 33'(den);
      q_r    <= NW'(num[32] ? 33'(-num) : 33'(num)) << FRACTION_BITS;
      neg_r  <= num[32] != den[32];
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 33'(trial - {1'b0, dmag_r});
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[32:0];
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/scfr_back.sv
// Back end: sequences calibration, filter and range check for one word.
// Uses scfr_pkg, scfr_mul, scfr_div and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_calibrate_filter_range_core_defines.svh"

module scfr_back
  import scfr_pkg::*;
#(
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS,
  parameter int MAX_POLY_DEGREE = DEF_MAX_POLY_DEGREE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  input  item_t       pop_item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam logic [2:0] MAX_DEG = 3'(MAX_POLY_DEGREE);
  localparam logic signed [41:0] XP_ONE = 42'(1) << FRACTION_BITS;
  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_LIN_W, S_DIV_W, S_TWO_W, S_PX, S_PT, S_FILT, S_FMUL, S_FSUM, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt, v_r, v_nxt, fv_r, fv_nxt;
  logic signed [44:0] acc_r, acc_nxt;
  logic signed [41:0] xp_r, xp_nxt, mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic signed [49:0] fprod_r, fprod_nxt, fsum_r, fsum_nxt;
  logic [2:0]  idx_r, idx_nxt, deg_r, deg_nxt;
  logic        err_r, err_nxt, primed_r, primed_nxt;
  logic        mul_start_r, mul_start_nxt, div_start_r, div_start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic               mul_done, div_done;
  logic signed [41:0] mul_res, div_quot;

  // Configuration fields
  logic [15:0]        alpha;
  logic [2:0]         deg_eff;
  logic signed [31:0] lin_scale, lin_off, tp_rl, tp_rh, tp_fl, tp_fh;
  logic signed [31:0] c0, coef_sel, lim_lo, lim_hi;
  logic signed [32:0] xd, ref_span, raw_span;
  logic signed [42:0] lin_sum, two_sum;
  logic signed [17:0] fm_a;
  logic signed [31:0] fm_b;
  logic signed [49:0] fm_p;
  logic signed [50:0] ftot;
  logic [50:0]        fmag, frnd;
  logic signed [51:0] fres;
  logic               out_of_range;

  assign alpha     = cfg.mode[21:6];
  assign deg_eff   = (cfg.mode[5:3] > MAX_DEG) ? MAX_DEG : cfg.mode[5:3];
  assign lin_scale = cfg.lin[63:32];
  assign lin_off   = cfg.lin[31:0];
  assign tp_rl     = cfg.tp_raw[31:0];
  assign tp_rh     = cfg.tp_raw[63:32];
  assign tp_fl     = cfg.tp_ref[31:0];
  assign tp_fh     = cfg.tp_ref[63:32];
  assign c0        = cfg.c01[31:0];
  assign lim_lo    = cfg.lim[31:0];
  assign lim_hi    = cfg.lim[63:32];
  assign raw_span  = 33'(tp_rh) - 33'(tp_rl);
  assign ref_span  = 33'(tp_fh) - 33'(tp_fl);

  // Coefficient of the current term
  always_comb begin
    case (idx_r)
      3'd1:    coef_sel = cfg.c01[63:32];
      3'd2:    coef_sel = cfg.c23[31:0];
      3'd3:    coef_sel = cfg.c23[63:32];
      3'd4:    coef_sel = cfg.c45[31:0];
      3'd5:    coef_sel = cfg.c45[63:32];
      default: coef_sel = c0;
    endcase
  end

  assign xd      = 33'(x_r) - 33'(tp_rl);
  assign lin_sum = 43'(mul_res) + 43'(lin_off);
  assign two_sum = 43'(mul_res) + 43'(tp_fl);

  // Filter multiplier, shared by the two weighted terms
  assign fm_a = (state_r == S_FILT) ? $signed({2'b0, alpha})
                                    : $signed({1'b0, 17'h10000 - {1'b0, alpha}});
  assign fm_b = (state_r == S_FILT) ? v_r : fv_r;
  assign fm_p = 50'(fm_a) * 50'(fm_b);

  // Round the weighted sum by 16 bits, ties away from zero
  assign ftot = 51'(fsum_r) + 51'(fprod_r);
  assign fmag = ftot[50] ? 51'(-ftot) : 51'(ftot);
  assign frnd = (fmag + 51'(32768)) >> 16;
  assign fres = ftot[50] ? -$signed({1'b0, frnd}) : $signed({1'b0, frnd});

  assign out_of_range = (lim_lo != lim_hi) && (v_r < lim_lo || v_r > lim_hi);

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFFFFFF;
    end
    if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign pop = (state_r == S_IDLE) && pop_valid;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    v_nxt         = v_r;
    fv_nxt        = fv_r;
    acc_nxt       = acc_r;
    xp_nxt        = xp_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    fprod_nxt     = fprod_r;
    fsum_nxt      = fsum_r;
    idx_nxt       = idx_r;
    deg_nxt       = deg_r;
    err_nxt       = err_r;
    primed_nxt    = primed_r;
    mul_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          x_nxt   = pop_item.sample;
          v_nxt   = pop_item.sample;
          err_nxt = 1'b0;
          case (pop_item.op)
            OP_ERR: begin
              err_nxt   = 1'b1;
              v_nxt     = '0;
              state_nxt = S_OUT;
            end
            OP_LIN: begin
              mul_a_nxt     = 42'(lin_scale);
              mul_b_nxt     = 42'(pop_item.sample);
              mul_start_nxt = 1'b1;
              state_nxt     = S_LIN_W;
            end
            OP_TWO: begin
              div_start_nxt = 1'b1;
              state_nxt     = S_DIV_W;
            end
            OP_POLY: begin
              acc_nxt = 45'(c0);
              deg_nxt = deg_eff;
              idx_nxt = 3'd1;
              if (deg_eff == 3'd0) begin
                v_nxt     = c0;
                state_nxt = S_FILT;
              end else begin
                mul_a_nxt     = XP_ONE;
                mul_b_nxt     = 42'(pop_item.sample);
                mul_start_nxt = 1'b1;
                state_nxt     = S_PX;
              end
            end
            default: state_nxt = S_FILT;
          endcase
        end
      end
      S_LIN_W: begin
        if (mul_done) begin
          v_nxt     = sat32(52'(lin_sum));
          state_nxt = S_FILT;
        end
      end
      S_DIV_W: begin
        if (div_done) begin
          mul_a_nxt     = div_quot;
          mul_b_nxt     = 42'(xd);
          mul_start_nxt = 1'b1;
          state_nxt     = S_TWO_W;
        end
      end
      S_TWO_W: begin
        if (mul_done) begin
          v_nxt     = sat32(52'(two_sum));
          state_nxt = S_FILT;
        end
      end
      S_PX: begin
        // Next power ready: multiply by its coefficient
        if (mul_done) begin
          xp_nxt        = mul_res;
          mul_a_nxt     = 42'(coef_sel);
          mul_b_nxt     = mul_res;
          mul_start_nxt = 1'b1;
          state_nxt     = S_PT;
        end
      end
      S_PT: begin
        if (mul_done) begin
          acc_nxt = acc_r + 45'(mul_res);
          if (idx_r == deg_r) begin
            v_nxt     = sat32(52'(acc_r + 45'(mul_res)));
            state_nxt = S_FILT;
          end else begin
            idx_nxt       = idx_r + 3'd1;
            mul_a_nxt     = xp_r;
            mul_b_nxt     = 42'(x_r);
            mul_start_nxt = 1'b1;
            state_nxt     = S_PX;
          end
        end
      end
      S_FILT: begin
        if (alpha == 16'd0) begin
          state_nxt = S_OUT;
        end else if (!primed_r) begin
          fv_nxt     = v_r;
          primed_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          fprod_nxt = fm_p;
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        fsum_nxt  = fprod_r;
        fprod_nxt = fm_p;
        state_nxt = S_FSUM;
      end
      S_FSUM: begin
        fv_nxt    = sat32(fres);
        v_nxt     = sat32(fres);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hand the word to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {x_r, v_r};
          out_user_nxt  = err_r ? ST_ERR : (out_of_range ? ST_RANGE : ST_OK);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fv_r        <= '0;
      primed_r    <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fv_r        <= fv_nxt;
      primed_r    <= primed_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    xp_r       <= xp_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    fprod_r    <= fprod_nxt;
    fsum_r     <= fsum_nxt;
    idx_r      <= idx_nxt;
    deg_r      <= deg_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  scfr_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a_in  (mul_a_r),
    .b_in  (mul_b_r),
    .done  (mul_done),
    .result(mul_res)
  );

  scfr_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start_r),
    .num  (ref_span),
    .den  (raw_span),
    .done (div_done),
    .quot (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SCFR_ASSERT_IMP(a_mul_done_waits, mul_done,
    (state_r == S_LIN_W) || (state_r == S_TWO_W) || (state_r == S_PX) || (state_r == S_PT),
    "product finished outside a wait state")
  `SCFR_ASSERT_IMP(a_div_done_waits, div_done, state_r == S_DIV_W,
    "slope finished outside its wait state")
  `SCFR_ASSERT_NXT(a_pop_leaves_idle, pop, state_r != S_IDLE,
    "sequencer stayed idle after taking a word")
  `SCFR_ASSERT_IMP(a_err_zero_value, out_tvalid && (out_tuser == ST_ERR),
    out_tdata[31:0] == 32'd0, "converter error word carries a nonzero value")

endmodule

### rtl/scfr_front.sv
// Front end: takes input words and classifies the work each one needs.
// Holds one word until the queue takes it; uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_front
  import scfr_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  // Smallest raw span that still gets interpolated (0.0001 in LSB, plus one)
  localparam int MinSpanLsb = ((1 << FRACTION_BITS) / 10000) + 1;
  localparam logic signed [32:0] MIN_SPAN = 33'(MinSpanLsb);

  logic               stage_valid_r;
  item_t              stage_r;
  item_t              item_in;
  logic signed [32:0] raw_span;
  logic               small_span;

  assign raw_span   = 33'($signed(cfg.tp_raw[63:32])) - 33'($signed(cfg.tp_raw[31:0]));
  assign small_span = (raw_span < MIN_SPAN) && (raw_span > -MIN_SPAN);

  // Classify the incoming word
  always_comb begin
    item_in.sample = $signed(in_tdata);
    if (in_tuser) begin
      item_in.op = OP_ERR;
    end else begin
      case (cfg.mode[2:0])
        MODE_LINEAR:    item_in.op = OP_LIN;
        MODE_TWO_POINT: item_in.op = small_span ? OP_PASS : OP_TWO;
        MODE_POLY:      item_in.op = OP_POLY;
        default:        item_in.op = OP_PASS;
      endcase
    end
  end

  assign in_tready  = !stage_valid_r || push_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_r;

  // Hold the word until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      stage_valid_r <= 1'b1;
    end else if (push_ready) begin
      stage_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      stage_r <= item_in;
    end
  end

endmodule

### rtl/scfr_fifo.sv
// Short queue of classified words between front end and back end.
// Register-based ring buffer; uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_fifo
  import scfr_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = count_r < CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/sensor_calibrate_filter_range_core.sv
// Sensor calibration core: each signed Q16.16 sample word (converter-error
// flag in tuser) yields one result word: calibrated value, raw echo and a
// status (ok, out of range, converter error). One sample is worked at a time
// while up to QUEUE_DEPTH more wait in the queue and one in the input stage.
// A converter-error sample goes straight to the output and a pass-through
// to the filter; linear mode takes one product; two-point mode runs the divider
// (it gives one quotient bit a cycle), then one product; polynomial mode takes
// two products per degree on the shared 21x21 multiplier. An active, already
// seeded filter adds the S_FMUL and S_FSUM states.
// Configuration registers are 64 bits at byte address 8*index.
`timescale 1ns / 1ps

module sensor_calibrate_filter_range_core
  import scfr_pkg::*;
#(
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS,
  parameter int MAX_POLY_DEGREE = DEF_MAX_POLY_DEGREE,
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,     // [31:0] sample_voltage
  input  logic              in_tuser,     // [0] adc_error
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,    // [31:0] calibrated_value, [63:32] raw_echo
  output logic [1:0]        out_tuser,    // [1:0] status
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t        cfg_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        push_valid, push_ready, pop_valid, pop;
  item_t       push_item, pop_item;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:   cfg_r.mode   <= cfg_pwdata[21:0];
        REG_LINEAR: cfg_r.lin    <= cfg_pwdata;
        REG_TP_RAW: cfg_r.tp_raw <= cfg_pwdata;
        REG_TP_REF: cfg_r.tp_ref <= cfg_pwdata;
        REG_C01:    cfg_r.c01    <= cfg_pwdata;
        REG_C23:    cfg_r.c23    <= cfg_pwdata;
        REG_C45:    cfg_r.c45    <= cfg_pwdata;
        REG_RANGE:  cfg_r.lim    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_MODE:   cfg_prdata = 64'(cfg_r.mode);
      REG_LINEAR: cfg_prdata = cfg_r.lin;
      REG_TP_RAW: cfg_prdata = cfg_r.tp_raw;
      REG_TP_REF: cfg_prdata = cfg_r.tp_ref;
      REG_C01:    cfg_prdata = cfg_r.c01;
      REG_C23:    cfg_prdata = cfg_r.c23;
      REG_C45:    cfg_prdata = cfg_r.c45;
      REG_RANGE:  cfg_prdata = cfg_r.lim;
      default:    cfg_prdata = '0;
    endcase
  end

  scfr_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  scfr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  scfr_back #(
    .FRACTION_BITS  (FRACTION_BITS),
    .MAX_POLY_DEGREE(MAX_POLY_DEGREE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### sim/tb_sensor_calibrate_filter_range_core.sv
// Self-checking bench for sensor_calibrate_filter_range_core: random
// calibration settings, sample words and stream stalls, checked against a local predictor.
// Depends on rtl/scfr_pkg.sv and the core itself.
`timescale 1ns / 1ps

module tb_sensor_calibrate_filter_range_core;
  import scfr_pkg::*;

  localparam int  NUM_PHASES  = 25;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam longint WIDE = 64'sd1 << 40;

  typedef struct {
    logic [31:0] sample;
    logic        adc_err;
  } sample_t;

  typedef struct {
    logic [31:0] value;
    logic [31:0] raw;
    logic [1:0]  status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid, out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state: register copy and filter
  logic [63:0] cal_regs [8];
  longint      ema_value = 0;
  bit          ema_primed = 0;

  sample_t  pending_samples[$];
  outcome_t expected_results[$];
  bit      sample_taken = 0;
  int      send_idle_pct = 0, recv_stall_pct = 0, recv_hold_cycles = 0;
  int      mismatches = 0, results_seen = 0, n_range = 0, n_err = 0;
  longint  cycle_count = 0;

  sensor_calibrate_filter_range_core dut (.*);

  always #1 clk = ~clk;

  function automatic longint clamp40(longint v);
    if (v > WIDE) return WIDE;
    if (v < -WIDE) return -WIDE;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint half_of(logic [63:0] r, bit upper);
    logic signed [31:0] h;
    h = upper ? r[63:32] : r[31:0];
    return longint'(h);
  endfunction

  // Rounded fixed-point product, ties away from zero, clamped to 2^40
  function automatic longint q_mul(longint x, longint y);
    longint cx, cy;
    longint unsigned a, b, ph, p, m;
    bit neg;
    cx = clamp40(x);
    cy = clamp40(y);
    neg = (cx < 0) != (cy < 0);
    a = (cx < 0) ? longint'(-cx) : cx;
    b = (cy < 0) ? longint'(-cy) : cy;
    ph = a * (b >> 20);
    if (ph >= (64'd1 << 43)) begin
      m = 64'd1 << 40;
    end else begin
      p = (ph << 20) + a * (b & 64'hFFFFF);
      m = (p + 64'd32768) >> 16;
      if (m > (64'd1 << 40)) m = 64'd1 << 40;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint calibrate(longint x);
    logic [2:0] mode;
    int deg;
    longint rl, rh, fl, fh, span_raw, slope, acc, xp;
    longint coeff [6];
    mode = cal_regs[REG_MODE][2:0];
    if (mode == MODE_LINEAR)
      return sat32(q_mul(half_of(cal_regs[REG_LINEAR], 1), x) +
                   half_of(cal_regs[REG_LINEAR], 0));
    if (mode == MODE_TWO_POINT) begin
      rl = half_of(cal_regs[REG_TP_RAW], 0);
      rh = half_of(cal_regs[REG_TP_RAW], 1);
      fl = half_of(cal_regs[REG_TP_REF], 0);
      fh = half_of(cal_regs[REG_TP_REF], 1);
      span_raw = rh - rl;
      // Pass through when the raw span is too narrow to divide by
      if (span_raw < 7 && span_raw > -7) return x;
      slope = clamp40(((fh - fl) * 65536) / span_raw);
      return sat32(fl + q_mul(slope, x - rl));
    end
    if (mode == MODE_POLY) begin
      coeff[0] = half_of(cal_regs[REG_C01], 0);
      coeff[1] = half_of(cal_regs[REG_C01], 1);
      coeff[2] = half_of(cal_regs[REG_C23], 0);
      coeff[3] = half_of(cal_regs[REG_C23], 1);
      coeff[4] = half_of(cal_regs[REG_C45], 0);
      coeff[5] = half_of(cal_regs[REG_C45], 1);
      deg = cal_regs[REG_MODE][5:3];
      if (deg > DEF_MAX_POLY_DEGREE) deg = DEF_MAX_POLY_DEGREE;
      acc = coeff[0];
      xp = 65536;
      for (int i = 1; i <= deg; i++) begin
        xp = q_mul(xp, x);
        acc += q_mul(coeff[i], xp);
      end
      return sat32(acc);
    end
    return x;
  endfunction

  // Work out the result word of one accepted sample; advances the filter
  task automatic predict_result(input sample_t s, output outcome_t r);
    longint v, lo, hi, sum;
    longint unsigned mag;
    longint alpha;
    logic signed [31:0] xs;
    xs = s.sample;
    r.raw = s.sample;
    if (s.adc_err) begin
      r.value = '0;
      r.status = ST_ERR;
      return;
    end
    v = calibrate(longint'(xs));
    alpha = cal_regs[REG_MODE][21:6];
    if (alpha != 0) begin
      if (!ema_primed) begin
        ema_value = v;
        ema_primed = 1;
      end else begin
        sum = alpha * v + (65536 - alpha) * ema_value;
        mag = (sum < 0) ? longint'(-sum) : sum;
        mag = (mag + 64'd32768) >> 16;
        ema_value = sat32((sum < 0) ? -longint'(mag) : longint'(mag));
      end
      v = ema_value;
    end
    lo = half_of(cal_regs[REG_RANGE], 0);
    hi = half_of(cal_regs[REG_RANGE], 1);
    r.status = (lo != hi && (v < lo || v > hi)) ? ST_RANGE : ST_OK;
    r.value = v[31:0];
  endtask

  // Input side: record accepted words and predict their results
  always @(posedge clk) begin
    outcome_t r;
    sample_t s;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      s.sample = in_tdata;
      s.adc_err = in_tuser;
      predict_result(s, r);
      expected_results.push_back(r);
      sample_taken = 1;
    end
  end

  // Output side: compare each result word with the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h / %h", out_tdata, out_tuser);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[31:0] !== e.value) begin
          $error("calibrated_value expected %h got %h", e.value, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== e.raw) begin
          $error("raw_echo expected %h got %h", e.raw, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tuser !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_tuser);
          mismatches++;
        end
        if (e.status == ST_RANGE) n_range++;
        if (e.status == ST_ERR) n_err++;
      end
    end
  end

  // Sample driver: hold a word until taken, else offer the next one or idle at random
  always @(negedge clk) begin
    bit taken;
    taken = sample_taken;
    sample_taken = 0;
    if (in_tvalid && taken) pending_samples.delete(0);
    if (in_tvalid && !taken) begin
      // hold the offered word
    end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_samples[0].sample;
      in_tuser  <= pending_samples[0].adc_err;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'(idx) << 3;
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cal_regs[idx] = (idx == REG_MODE) ? (val & 64'h3FFFFF) : val;
  endtask

  // Q16.16 value with extremes weighted in
  function automatic logic [31:0] pick_q();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(4))
      0, 1: return 16'h0;
      2: return 16'hFFFF;
      3: return 16'h1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_results.size() > 0 || in_tvalid)
      @(posedge clk);
  endtask

  task automatic queue_sample(input logic [31:0] v, input logic err);
    sample_t s;
    s.sample = v;
    s.adc_err = err;
    pending_samples.push_back(s);
  endtask

  // Apply a calibration setting; phase decides mode and how extreme
  task automatic program_phase(input int p);
    logic [2:0] mode;
    logic [31:0] rl, rh, lo, hi;
    mode = (p < 8) ? 3'(p) : 3'($urandom_range(7));
    if (p % 5 == 1) mode = MODE_POLY;
    cfg_write(REG_MODE, {42'd0, pick_alpha(), 3'($urandom_range(7)), mode});
    cfg_write(REG_LINEAR, {pick_q(), pick_q()});
    rl = pick_q();
    case ($urandom_range(3))
      0: rh = rl + 32'($signed($urandom_range(0, 12)) - 6);  // too narrow
      1: rh = rl + ($urandom_range(1) ? 32'd7 : -32'd7);
      default: rh = pick_q();
    endcase
    cfg_write(REG_TP_RAW, {rh, rl});
    cfg_write(REG_TP_REF, {pick_q(), pick_q()});
    cfg_write(REG_C01, {pick_q(), pick_q()});
    cfg_write(REG_C23, {pick_q(), pick_q()});
    cfg_write(REG_C45, {pick_q(), pick_q()});
    lo = pick_q();
    case ($urandom_range(3))
      0: hi = lo;                                 // check disabled
      1: hi = lo - 32'($urandom_range(1, 1000));  // flags everything unless hi wraps
      default: hi = lo + 32'($urandom_range(0, 1 << 20));
    endcase
    if (p == 2) begin
      lo = 32'h8000_0000;
      hi = 32'h7FFF_FFFF;
    end
    cfg_write(REG_RANGE, {hi, lo});
  endtask

  initial begin
    for (int i = 0; i < 8; i++) cal_regs[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at reset settings, then in each of the first eight phases
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h0, 1'b0);
    queue_sample(32'h1, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h8000_0000, 1'b1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (p < 8) begin
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h0001_0000, 1'b0);
      end
      // Fill the core while the receiver holds off
      if (p == 3 || p == 17) begin
        @(posedge clk);
        recv_hold_cycles = 600;
      end
      for (int i = 0; i < 68; i++) begin
        queue_sample(pick_q(), $urandom_range(9) == 0);
        // Pause the sender until the core drains, mid-phase
        if (i == 34 && p % 3 == 0) wait_idle();
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      mismatches++;
    end
    $display("checked %0d result words over %0d settings (%0d out of range, %0d converter errors)",
             results_seen, NUM_PHASES + 1, n_range, n_err);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
